[rtl/crrp_pkg.sv]
// ----------------------------------------------------------------------------
// crrp_pkg
// Shared widths, event codes and register indexes of the congestion rate
// reaction point.
// ----------------------------------------------------------------------------
package crrp_pkg;

   localparam int RATE_W     = 27;
   localparam int ALPHA_W    = 17;
   localparam int TIME_W     = 48;
   localparam int CNT_W      = 16;
   localparam int GEN_W      = 32;
   localparam int BYTES_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // 1.0 in Q1.16
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   // event codes on req_func
   localparam logic [1:0] EVT_CNP    = 2'd0;
   localparam logic [1:0] EVT_TIMER  = 2'd1;
   localparam logic [1:0] EVT_BYTES  = 2'd2;
   localparam logic [1:0] EVT_PACKET = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINE_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ADD_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_PER   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BYTE_LIMIT  = 3'd6;

endpackage

[rtl/crrp_div.sv]
// ----------------------------------------------------------------------------
// crrp_div
// Restoring divider, one quotient bit per cycle, for the inter-packet gap.
// ----------------------------------------------------------------------------
module crrp_div
   import crrp_pkg::*;
#(
   parameter int DVD_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   localparam int CNT_BITS = $clog2(DVD_W + 1);

   logic [RATE_W:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [RATE_W:0]     rem_sh;
   logic [RATE_W+1:0]   diff;

   always_comb begin
      rem_sh  = {rem_ff[RATE_W-1:0], quo_ff[DVD_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_BITS'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shifted value fits
         if (!diff[RATE_W+1]) begin
            rem_in = diff[RATE_W:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/congestion_rate_reaction_point_top.sv]
// ----------------------------------------------------------------------------
// congestion_rate_reaction_point_top
// Sender-side congestion rate controller: alpha tracking, rate cut, fast
// recovery, additive increase and inter-packet gap.
// ----------------------------------------------------------------------------
// One event is processed at a time; req_ready is high only while the sequencer
// is idle. A congestion notice runs alpha multiply and write-back, then rate
// multiply and write-back; a timer expiry the alpha steps, then count, target
// and current; a byte-counter expiry count, target and current; a packet send
// waits on the divider, one bit of the gap quotient per cycle; its width DVD_W
// is the bit width of FRAME_BYTES * 8000 * 2^RATE_FRAC_BITS. A single 27x18
// multiplier is shared by the alpha update and the rate cut. Results sit in an
// output register, so a new event is taken while the last result waits; the
// sequencer holds only if a second result is ready before the first is taken.
module congestion_rate_reaction_point_top
   import crrp_pkg::*;
#(
   parameter int FRAME_BYTES    = 1500,
   parameter int RATE_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [TIME_W-1:0]     req_now_ns,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RATE_W-1:0]     rsp_rate_now,
   output logic [RATE_W-1:0]     rsp_target_now,
   output logic [ALPHA_W-1:0]    rsp_alpha_now,
   output logic                  rsp_arm_timer,
   output logic [TIME_W-1:0]     rsp_timer_due_ns,
   output logic [GEN_W-1:0]      rsp_timer_generation,
   output logic [TIME_W-1:0]     rsp_packet_due_ns,
   output logic                  rsp_byte_counter_due,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [63:0] DIVIDEND =
      (64'(FRAME_BYTES) * 64'd8000) << RATE_FRAC_BITS;
   localparam int DVD_W = $clog2(DIVIDEND + 64'd1);
   localparam int PROD_W = RATE_W + ALPHA_W + 1;
   localparam logic [ALPHA_W:0]  ALPHA_TWO  = 18'd131072;
   localparam logic [RATE_W-1:0] RATE_FLOOR = RATE_W'(1) << RATE_FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALPHA_MUL,
      S_ALPHA_WB,
      S_RATE_MUL,
      S_RATE_WB,
      S_COUNT,
      S_TARGET,
      S_CURRENT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           func_ff, func_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [RATE_W-1:0]    line_ff, line_in;
   logic [ALPHA_W-1:0]   gain_ff, gain_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [RATE_W-1:0]    step_ff, step_in;
   logic [31:0]          period_ff, period_in;
   logic [BYTES_W-1:0]   blimit_ff, blimit_in;
   logic [RATE_W-1:0]    cur_ff, cur_in;
   logic [RATE_W-1:0]    tgt_ff, tgt_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [CNT_W-1:0]     tcnt_ff, tcnt_in;
   logic [CNT_W-1:0]     bcnt_ff, bcnt_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [GEN_W-1:0]     gen_ff, gen_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 arm_ff, arm_in;
   logic                 bdue_ff, bdue_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic [RATE_W-1:0]    rsp_target_ff, rsp_target_in;
   logic [ALPHA_W-1:0]   rsp_alpha_ff, rsp_alpha_in;
   logic                 rsp_arm_ff, rsp_arm_in;
   logic [TIME_W-1:0]    rsp_tdue_ff, rsp_tdue_in;
   logic [GEN_W-1:0]     rsp_gen_ff, rsp_gen_in;
   logic [TIME_W-1:0]    rsp_pdue_ff, rsp_pdue_in;
   logic                 rsp_bdue_ff, rsp_bdue_in;

   logic [ALPHA_W-1:0]   gain_eff;
   logic [ALPHA_W-1:0]   astart_clamped;
   logic [RATE_W-1:0]    mul_a;
   logic [ALPHA_W:0]     mul_b;
   logic [RATE_W-1:0]    cut_rate;
   logic [RATE_W:0]      tgt_sum;
   logic [RATE_W:0]      cur_sum;
   logic [RATE_W-1:0]    cur_avg;
   logic [BYTES_W:0]     bytes_sum;
   logic [BYTES_W-1:0]   bytes_sat;
   logic [CNT_W-1:0]     cnt_max;
   logic                 div_start;
   logic                 div_done;
   logic [DVD_W-1:0]     div_quo;
   logic [RATE_W-1:0]    div_divisor;

   crrp_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DVD_W'(DIVIDEND)),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign div_start   = (state_ff == S_DIV_GO);
   assign div_divisor = (cur_ff == '0) ? RATE_W'(1) : cur_ff;

   always_comb begin
      gain_eff       = (gain_ff > ALPHA_ONE) ? ALPHA_ONE : gain_ff;
      astart_clamped = (csr_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                           : csr_data[ALPHA_W-1:0];
      // shared multiplier operands
      if (state_ff == S_RATE_MUL) begin
         mul_a = cur_ff;
         mul_b = ALPHA_TWO - {1'b0, alpha_ff};
      end else begin
         mul_a = RATE_W'(alpha_ff);
         mul_b = {1'b0, ALPHA_ONE - gain_eff};
      end
      cut_rate  = prod_ff[ALPHA_W+RATE_W-1:ALPHA_W];
      tgt_sum   = {1'b0, tgt_ff} + {1'b0, step_ff};
      cur_sum   = {1'b0, cur_ff} + {1'b0, tgt_ff};
      cur_avg   = cur_sum[RATE_W:1];
      bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(FRAME_BYTES);
      bytes_sat = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
      cnt_max   = (tcnt_ff > bcnt_ff) ? tcnt_ff : bcnt_ff;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      line_in       = line_ff;
      gain_in       = gain_ff;
      k_in          = k_ff;
      step_in       = step_ff;
      period_in     = period_ff;
      blimit_in     = blimit_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      alpha_in      = alpha_ff;
      tcnt_in       = tcnt_ff;
      bcnt_in       = bcnt_ff;
      bytes_in      = bytes_ff;
      gen_in        = gen_ff;
      prod_in       = prod_ff;
      arm_in        = arm_ff;
      bdue_in       = bdue_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_target_in = rsp_target_ff;
      rsp_alpha_in  = rsp_alpha_ff;
      rsp_arm_in    = rsp_arm_ff;
      rsp_tdue_in   = rsp_tdue_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_pdue_in   = rsp_pdue_ff;
      rsp_bdue_in   = rsp_bdue_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               now_in  = req_now_ns;
               arm_in  = 1'b0;
               bdue_in = 1'b0;
               case (req_func)
                  EVT_CNP:    state_in = S_ALPHA_MUL;
                  EVT_TIMER:  state_in = S_ALPHA_MUL;
                  EVT_BYTES:  state_in = S_COUNT;
                  EVT_PACKET: state_in = S_DIV_GO;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_ALPHA_MUL: begin
            prod_in  = PROD_W'(mul_a * mul_b);
            state_in = S_ALPHA_WB;
         end
         S_ALPHA_WB: begin
            if (func_ff == EVT_CNP) begin
               alpha_in = prod_ff[2*16:16] + gain_eff;
               state_in = S_RATE_MUL;
            end else begin
               alpha_in = prod_ff[2*16:16];
               state_in = S_COUNT;
            end
         end
         S_RATE_MUL: begin
            prod_in  = PROD_W'(mul_a * mul_b);
            state_in = S_RATE_WB;
         end
         S_RATE_WB: begin
            tgt_in   = cur_ff;
            cur_in   = (cut_rate < RATE_FLOOR) ? RATE_FLOOR : cut_rate;
            tcnt_in  = '0;
            bcnt_in  = '0;
            bytes_in = '0;
            gen_in   = gen_ff + 1'b1;
            arm_in   = 1'b1;
            state_in = S_DONE;
         end
         S_COUNT: begin
            if (func_ff == EVT_TIMER) begin
               tcnt_in = (tcnt_ff == '1) ? tcnt_ff : tcnt_ff + 1'b1;
            end else begin
               bcnt_in = (bcnt_ff == '1) ? bcnt_ff : bcnt_ff + 1'b1;
            end
            state_in = S_TARGET;
         end
         S_TARGET: begin
            // additive increase once either counter has reached k
            if (cnt_max >= k_ff) begin
               tgt_in = (tgt_sum > {1'b0, line_ff}) ? line_ff : tgt_sum[RATE_W-1:0];
            end
            state_in = S_CURRENT;
         end
         S_CURRENT: begin
            cur_in   = (cur_avg > line_ff) ? line_ff : cur_avg;
            arm_in   = (func_ff == EVT_TIMER) &&
                       (((cur_avg > line_ff) ? line_ff : cur_avg) < line_ff);
            state_in = S_DONE;
         end
         S_DIV_GO: begin
            if (bytes_sat >= blimit_ff) begin
               bytes_in = '0;
               bdue_in  = 1'b1;
            end else begin
               bytes_in = bytes_sat;
            end
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = cur_ff;
               rsp_target_in = tgt_ff;
               rsp_alpha_in  = alpha_ff;
               rsp_arm_in    = arm_ff;
               rsp_tdue_in   = arm_ff ? now_ff + TIME_W'(period_ff) : '0;
               rsp_gen_in    = gen_ff;
               rsp_pdue_in   = (func_ff == EVT_PACKET) ? now_ff + TIME_W'(div_quo) : '0;
               rsp_bdue_in   = bdue_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid) begin
         case (csr_index)
            REG_LINE_RATE: begin
               line_in = csr_data[RATE_W-1:0];
               cur_in  = csr_data[RATE_W-1:0];
               tgt_in  = csr_data[RATE_W-1:0];
            end
            REG_ALPHA_GAIN:  gain_in   = csr_data[ALPHA_W-1:0];
            REG_ALPHA_START: alpha_in  = astart_clamped;
            REG_RECOVERY:    k_in      = csr_data[CNT_W-1:0];
            REG_ADD_STEP:    step_in   = csr_data[RATE_W-1:0];
            REG_TIMER_PER:   period_in = csr_data;
            REG_BYTE_LIMIT:  blimit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_ff      <= 27'd25600000;
         gain_ff      <= 17'd256;
         k_ff         <= 16'd5;
         step_ff      <= 27'd1280;
         period_ff    <= 32'd55000;
         blimit_ff    <= 32'd10485760;
         cur_ff       <= 27'd25600000;
         tgt_ff       <= 27'd25600000;
         alpha_ff     <= ALPHA_ONE;
         tcnt_ff      <= '0;
         bcnt_ff      <= '0;
         bytes_ff     <= '0;
         gen_ff       <= '0;
         arm_ff       <= 1'b0;
         bdue_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_ff      <= line_in;
         gain_ff      <= gain_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         period_ff    <= period_in;
         blimit_ff    <= blimit_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         alpha_ff     <= alpha_in;
         tcnt_ff      <= tcnt_in;
         bcnt_ff      <= bcnt_in;
         bytes_ff     <= bytes_in;
         gen_ff       <= gen_in;
         arm_ff       <= arm_in;
         bdue_ff      <= bdue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      now_ff        <= now_in;
      prod_ff       <= prod_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_target_ff <= rsp_target_in;
      rsp_alpha_ff  <= rsp_alpha_in;
      rsp_arm_ff    <= rsp_arm_in;
      rsp_tdue_ff   <= rsp_tdue_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_pdue_ff   <= rsp_pdue_in;
      rsp_bdue_ff   <= rsp_bdue_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rate_now         = rsp_rate_ff;
   assign rsp_target_now       = rsp_target_ff;
   assign rsp_alpha_now        = rsp_alpha_ff;
   assign rsp_arm_timer        = rsp_arm_ff;
   assign rsp_timer_due_ns     = rsp_tdue_ff;
   assign rsp_timer_generation = rsp_gen_ff;
   assign rsp_packet_due_ns    = rsp_pdue_ff;
   assign rsp_byte_counter_due = rsp_bdue_ff;

endmodule

[rtl/crrp_checker.sv]
// ----------------------------------------------------------------------------
// crrp_checker
// Port-level checks of the congestion rate reaction point, bound to the top.
// ----------------------------------------------------------------------------
module crrp_checker
   import crrp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ALPHA_W-1:0]    rsp_alpha_now,
   input logic                  rsp_arm_timer,
   input logic [TIME_W-1:0]     rsp_timer_due_ns,
   input logic [TIME_W-1:0]     rsp_packet_due_ns,
   input logic                  rsp_byte_counter_due
);

   // transactions accepted on req_ but not yet delivered on rsp_
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an event is in progress");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0 && pend_ff != 2'd3)
      else $error("response without a pending request");

   a_tdue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_arm_timer |-> rsp_timer_due_ns == '0)
      else $error("timer due time set without arming");

   a_packet_no_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_packet_due_ns != '0 || rsp_byte_counter_due) |-> !rsp_arm_timer)
      else $error("packet send response arms the rate timer");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha_now <= ALPHA_ONE)
      else $error("alpha above one");

endmodule

bind congestion_rate_reaction_point_top crrp_checker u_crrp_checker (.*);

[tb/sv/tb_congestion_rate_reaction_point_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_congestion_rate_reaction_point_top
// Sends congestion, timer, byte-counter and packet events into the reaction
// point and checks each result against an in-bench model of alpha, rate cut,
// recovery, additive increase and packet gap, under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_congestion_rate_reaction_point_top
   import crrp_pkg::*;
();

   localparam int PKT_BYTES    = 1500;
   localparam int FRAC_BITS    = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_ITEMS  = 210;

   // index with no register behind it, writes are dropped
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 3'd7;

   localparam logic [63:0] GAP_DIVIDEND = (64'(PKT_BYTES) * 64'd8000) << FRAC_BITS;
   localparam logic [63:0] RATE_FLOOR   = 64'd1 << FRAC_BITS;

   typedef struct packed {
      logic [RATE_W-1:0]  rate;
      logic [RATE_W-1:0]  target;
      logic [ALPHA_W-1:0] alpha;
      logic               arm;
      logic [TIME_W-1:0]  timer_due;
      logic [GEN_W-1:0]   gen;
      logic [TIME_W-1:0]  packet_due;
      logic               byte_due;
   } rate_update_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func   = EVT_CNP;
   logic [TIME_W-1:0]     req_now_ns = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [RATE_W-1:0]     rsp_rate_now;
   logic [RATE_W-1:0]     rsp_target_now;
   logic [ALPHA_W-1:0]    rsp_alpha_now;
   logic                  rsp_arm_timer;
   logic [TIME_W-1:0]     rsp_timer_due_ns;
   logic [GEN_W-1:0]      rsp_timer_generation;
   logic [TIME_W-1:0]     rsp_packet_due_ns;
   logic                  rsp_byte_counter_due;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_LINE_RATE;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // controller model: registers and state
   logic [RATE_W-1:0]  cfg_line_rate;
   logic [RATE_W-1:0]  cfg_add_step;
   logic [ALPHA_W-1:0] cfg_gain;
   logic [ALPHA_W-1:0] cfg_alpha_start;
   logic [CNT_W-1:0]   cfg_recovery;
   logic [31:0]        cfg_timer_per;
   logic [31:0]        cfg_byte_limit;
   logic [RATE_W-1:0]  cur_rate;
   logic [RATE_W-1:0]  tgt_rate;
   logic [ALPHA_W-1:0] alpha_est;
   logic [CNT_W-1:0]   timer_cnt;
   logic [CNT_W-1:0]   byte_evt_cnt;
   logic [BYTES_W-1:0] bytes_sent;
   logic [GEN_W-1:0]   generation;

   rate_update_type    pending_updates[$];
   logic [TIME_W-1:0]  event_time  = '0;
   bit                 tx_idle     = 1'b1;
   bit                 rx_idle     = 1'b1;
   int                 fail_count  = 0;
   int                 idle_cycles = 0;
   int                 hold_left   = 0;
   int                 stall_left  = 0;

   congestion_rate_reaction_point_top #(
      .FRAME_BYTES   (PKT_BYTES),
      .RATE_FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_now_ns          (req_now_ns),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rate_now        (rsp_rate_now),
      .rsp_target_now      (rsp_target_now),
      .rsp_alpha_now       (rsp_alpha_now),
      .rsp_arm_timer       (rsp_arm_timer),
      .rsp_timer_due_ns    (rsp_timer_due_ns),
      .rsp_timer_generation(rsp_timer_generation),
      .rsp_packet_due_ns   (rsp_packet_due_ns),
      .rsp_byte_counter_due(rsp_byte_counter_due),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [ALPHA_W-1:0] clamp_q16(input logic [ALPHA_W-1:0] v);
      return (v > ALPHA_ONE) ? ALPHA_ONE : v;
   endfunction

   // fast recovery, with additive increase of the target once a counter hits k
   function automatic void raise_rate();
      logic [CNT_W-1:0] most;
      logic [63:0]      sum;
      most = (timer_cnt > byte_evt_cnt) ? timer_cnt : byte_evt_cnt;
      if (most >= cfg_recovery) begin
         sum = 64'(tgt_rate) + 64'(cfg_add_step);
         tgt_rate = (sum > 64'(cfg_line_rate)) ? cfg_line_rate : sum[RATE_W-1:0];
      end
      sum = (64'(cur_rate) + 64'(tgt_rate)) >> 1;
      cur_rate = (sum > 64'(cfg_line_rate)) ? cfg_line_rate : sum[RATE_W-1:0];
   endfunction

   function automatic rate_update_type predict_event(input logic [1:0] func,
                                                     input logic [TIME_W-1:0] now);
      rate_update_type upd;
      logic [63:0]     g;
      logic [63:0]     prod;
      logic [63:0]     cut;
      logic [63:0]     gap;
      logic [63:0]     sum;
      upd = '0;
      g = 64'(clamp_q16(cfg_gain));
      case (func)
         EVT_CNP: begin
            tgt_rate  = cur_rate;
            prod      = (64'(ALPHA_ONE) - g) * 64'(alpha_est);
            sum       = (prod >> 16) + g;
            alpha_est = sum[ALPHA_W-1:0];
            cut = (64'(cur_rate) * ((64'(ALPHA_ONE) << 1) - 64'(alpha_est))) >> 17;
            if (cut < RATE_FLOOR)
               cut = RATE_FLOOR;
            cur_rate     = cut[RATE_W-1:0];
            timer_cnt    = '0;
            byte_evt_cnt = '0;
            bytes_sent   = '0;
            generation   = generation + 1'b1;
            upd.arm      = 1'b1;
         end
         EVT_TIMER: begin
            prod      = (64'(ALPHA_ONE) - g) * 64'(alpha_est);
            sum       = prod >> 16;
            alpha_est = sum[ALPHA_W-1:0];
            if (timer_cnt != '1)
               timer_cnt = timer_cnt + 1'b1;
            raise_rate();
            upd.arm = (cur_rate < cfg_line_rate);
         end
         EVT_BYTES: begin
            if (byte_evt_cnt != '1)
               byte_evt_cnt = byte_evt_cnt + 1'b1;
            raise_rate();
         end
         EVT_PACKET: begin
            // a zero rate divides as one
            gap = GAP_DIVIDEND / ((cur_rate == '0) ? 64'd1 : 64'(cur_rate));
            upd.packet_due = now + gap[TIME_W-1:0];
            sum = 64'(bytes_sent) + 64'(PKT_BYTES);
            if (sum > 64'hFFFF_FFFF)
               sum = 64'hFFFF_FFFF;
            if (sum >= 64'(cfg_byte_limit)) begin
               bytes_sent   = '0;
               upd.byte_due = 1'b1;
            end else begin
               bytes_sent = sum[BYTES_W-1:0];
            end
         end
         default: ;
      endcase
      if (upd.arm)
         upd.timer_due = now + cfg_timer_per;
      upd.rate   = cur_rate;
      upd.target = tgt_rate;
      upd.alpha  = alpha_est;
      upd.gen    = generation;
      return upd;
   endfunction

   function automatic logic [TIME_W-1:0] next_time();
      logic [63:0] jump;
      if ($urandom_range(0, 19) == 0) begin
         jump = {$urandom, $urandom};
         event_time = jump[TIME_W-1:0];
      end else begin
         event_time = event_time + $urandom_range(0, 60000);
      end
      return event_time;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_event(input logic [1:0] func, input logic [TIME_W-1:0] now);
      int gap;
      gap = tx_idle ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid  = 1'b1;
      req_func   = func;
      req_now_ns = now;
      do @(posedge clock); while (!req_ready);
      pending_updates.push_back(predict_event(func, now));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_updates.size() != 0)
         @(negedge clock);
   endtask

   // only called with no event in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LINE_RATE: begin
            cfg_line_rate = data[RATE_W-1:0];
            cur_rate      = cfg_line_rate;
            tgt_rate      = cfg_line_rate;
         end
         REG_ALPHA_GAIN:  cfg_gain = data[ALPHA_W-1:0];
         REG_ALPHA_START: begin
            cfg_alpha_start = data[ALPHA_W-1:0];
            alpha_est       = clamp_q16(cfg_alpha_start);
         end
         REG_RECOVERY:    cfg_recovery   = data[CNT_W-1:0];
         REG_ADD_STEP:    cfg_add_step   = data[RATE_W-1:0];
         REG_TIMER_PER:   cfg_timer_per  = data;
         REG_BYTE_LIMIT:  cfg_byte_limit = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_event(EVT_PACKET, '0);
      send_event(EVT_TIMER, '1);
      send_event(EVT_CNP, '1);
      send_event(EVT_BYTES, 48'd100);
      send_event(EVT_PACKET, '1);
      send_event(EVT_TIMER, 48'd200);
   endtask

   task automatic test_register_extremes();
      wait_drain();
      write_reg(REG_ALPHA_GAIN, 32'h0001_FFFF);   // gain above one
      write_reg(REG_ALPHA_START, 32'hFFFF_FFFF);
      write_reg(REG_RECOVERY, 32'd0);
      write_reg(REG_ADD_STEP, 32'h07FF_FFFF);
      write_reg(REG_TIMER_PER, 32'hFFFF_FFFF);
      write_reg(REG_BYTE_LIMIT, 32'd0);
      write_reg(REG_LINE_RATE, 32'h07FF_FFFF);
      write_reg(REG_NONE, $urandom);
      send_event(EVT_CNP, next_time());
      send_event(EVT_TIMER, next_time());
      send_event(EVT_BYTES, next_time());
      send_event(EVT_PACKET, next_time());
      send_event(EVT_PACKET, next_time());
      wait_drain();
      write_reg(REG_ALPHA_GAIN, 32'd0);
      write_reg(REG_ALPHA_START, 32'd0);
      write_reg(REG_RECOVERY, 32'h0000_FFFF);
      write_reg(REG_ADD_STEP, 32'd0);
      write_reg(REG_TIMER_PER, 32'd0);
      write_reg(REG_BYTE_LIMIT, 32'd1500);
      write_reg(REG_LINE_RATE, 32'd256);
      send_event(EVT_CNP, next_time());
      send_event(EVT_TIMER, next_time());
      send_event(EVT_PACKET, next_time());
      send_event(EVT_PACKET, next_time());
   endtask

   // line rate below the floor, then a zero line rate
   task automatic test_special_rates();
      wait_drain();
      write_reg(REG_ALPHA_GAIN, 32'd4096);
      write_reg(REG_ALPHA_START, 32'd65536);
      write_reg(REG_LINE_RATE, 32'd100);
      send_event(EVT_CNP, next_time());
      send_event(EVT_PACKET, next_time());
      send_event(EVT_TIMER, next_time());
      wait_drain();
      write_reg(REG_LINE_RATE, 32'd0);
      send_event(EVT_PACKET, next_time());
      send_event(EVT_CNP, next_time());
      send_event(EVT_BYTES, next_time());
   endtask

   task automatic test_backpressure();
      wait_drain();
      write_reg(REG_LINE_RATE, 32'd25600000);
      write_reg(REG_RECOVERY, 32'd3);
      write_reg(REG_ADD_STEP, 32'd1280);
      write_reg(REG_BYTE_LIMIT, 32'd4500);
      hold_left = 300;
      repeat (12)
         send_event(2'($urandom_range(0, 3)), next_time());
      wait_drain();
      repeat (8)
         send_event(2'($urandom_range(0, 3)), next_time());
   endtask

   task automatic test_random_traffic();
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [1:0]            func;
      int                    pick;
      int                    roll;
      for (int phase = 0; phase < 6; phase++) begin
         wait_drain();
         tx_idle = (phase % 3 != 2);
         rx_idle = (phase % 3 != 2);
         for (int i = 0; i < 8; i++) begin
            idx = i[CSR_IDX_W-1:0];
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, 9);
               case (idx)
                  REG_LINE_RATE:   data = (pick == 0) ? 32'd256 :
                                          (pick == 1) ? 32'h07FF_FFFF :
                                          $urandom_range(256, 102400000);
                  REG_ALPHA_GAIN:  data = (pick == 0) ? 32'd65536 : $urandom_range(0, 8192);
                  REG_ALPHA_START: data = (pick == 0) ? 32'h0001_FFFF :
                                          $urandom_range(0, 65536);
                  REG_RECOVERY:    data = (pick == 0) ? 32'h0000_FFFF : $urandom_range(0, 12);
                  REG_ADD_STEP:    data = (pick == 0) ? 32'h07FF_FFFF :
                                          $urandom_range(0, 1 << 20);
                  REG_TIMER_PER:   data = $urandom;
                  REG_BYTE_LIMIT:  data = (pick == 0) ? $urandom : $urandom_range(1500, 40000);
                  default:         data = $urandom;
               endcase
               // stray upper bits; each register keeps only its own field width
               if (pick == 9)
                  data = data | ($urandom & 32'hFFFE_0000);
               write_reg(idx, data);
            end
         end
         repeat (PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            func = (roll < 10) ? EVT_CNP :
                   (roll < 35) ? EVT_TIMER :
                   (roll < 55) ? EVT_BYTES : EVT_PACKET;
            send_event(func, next_time());
         end
      end
   endtask

   // result side: long hold-off when asked, else a short stall per transaction
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready = 1'b0;
      end else if (rsp_valid && stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      rate_update_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            $error("result transaction with nothing outstanding, rate_now %0d", rsp_rate_now);
            fail_count++;
         end else begin
            want = pending_updates.pop_front();
            check_field("rate_now", want.rate, rsp_rate_now);
            check_field("target_now", want.target, rsp_target_now);
            check_field("alpha_now", want.alpha, rsp_alpha_now);
            check_field("arm_timer", want.arm, rsp_arm_timer);
            check_field("timer_due_ns", want.timer_due, rsp_timer_due_ns);
            check_field("timer_generation", want.gen, rsp_timer_generation);
            check_field("packet_due_ns", want.packet_due, rsp_packet_due_ns);
            check_field("byte_counter_due", want.byte_due, rsp_byte_counter_due);
         end
         stall_left = rx_idle ? $urandom_range(0, 5) : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      cfg_line_rate   = 27'd25600000;
      cfg_gain        = 17'd256;
      cfg_alpha_start = 17'd65536;
      cfg_recovery    = 16'd5;
      cfg_add_step    = 27'd1280;
      cfg_timer_per   = 32'd55000;
      cfg_byte_limit  = 32'd10485760;
      cur_rate        = cfg_line_rate;
      tgt_rate        = cfg_line_rate;
      alpha_est       = clamp_q16(cfg_alpha_start);
      timer_cnt       = '0;
      byte_evt_cnt    = '0;
      bytes_sent      = '0;
      generation      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_special_rates();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_updates.size() != 0) begin
         $error("%0d results never arrived", pending_updates.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
